[design/uvsph_pkg.sv]
// ----------------------------------------------------------------------------
// uvsph_pkg
// Shared widths, codes, transaction types and the CORDIC constants of the
// UV sphere cell vertex core.
// ----------------------------------------------------------------------------
package uvsph_pkg;

	localparam int MAX_SLICES_DEF = 256;
	localparam int MAX_STACKS_DEF = 256;

	localparam int RAD_W = 16;
	localparam int CNT_W = 9;
	localparam int IDX_W = 8;
	localparam int POS_W = 17;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STACKS = 2'd2;

	localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
	localparam logic [CNT_W-1:0] SLICES_RST = 9'd3;
	localparam logic [CNT_W-1:0] STACKS_RST = 9'd2;

	// long division: numerator is index * 2^32 (or 2^31) plus half the divisor
	localparam int DIV_NUM_W = 41;
	localparam int DIV_STEPS = 6;
	localparam int DIV_STAGES = (DIV_NUM_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int ANG_W = 32;

	localparam int CORDIC_N = 30;
	localparam int CORDIC_PER = 3;
	localparam int CORDIC_STAGES = (CORDIC_N + CORDIC_PER - 1) / CORDIC_PER;
	localparam int CORDIC_LAT = CORDIC_STAGES + 1;
	localparam int CW = 33;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sh026DD3B6A;
	localparam int TRIG_W = 16;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FEW_SLICES = 2'd1,
		ST_FEW_STACKS = 2'd2,
		ST_RANGE      = 2'd3
	} status_t;

	typedef struct packed {
		logic             vld;
		logic [CNT_W-1:0] lat_idx;
		logic [CNT_W-1:0] lon_idx;
		logic [CNT_W-1:0] nt;
		logic [CNT_W-1:0] ns;
		status_t          status;
		logic             last;
	} req_t;

	typedef struct packed {
		logic    vld;
		status_t status;
		logic    last;
	} side_t;

	// arctangent of 2^-k in units of 2^32 per turn
	function automatic logic signed [CW-1:0] atan_turn(input int k);
		case (k)
			0: return 33'sh020000000;
			1: return 33'sh012E4051E;
			2: return 33'sh009FB385B;
			3: return 33'sh0051111D4;
			4: return 33'sh0028B0D43;
			5: return 33'sh00145D7E1;
			6: return 33'sh000A2F61E;
			7: return 33'sh000517C55;
			8: return 33'sh00028BE53;
			9: return 33'sh000145F2F;
			10: return 33'sh0000A2F98;
			11: return 33'sh0000517CC;
			12: return 33'sh000028BE6;
			13: return 33'sh0000145F3;
			14: return 33'sh00000A2F9;
			15: return 33'sh00000517C;
			16: return 33'sh0000028BE;
			17: return 33'sh00000145F;
			18: return 33'sh000000A2F;
			19: return 33'sh000000517;
			20: return 33'sh00000028B;
			21: return 33'sh000000145;
			22: return 33'sh0000000A2;
			23: return 33'sh000000051;
			24: return 33'sh000000028;
			25: return 33'sh000000014;
			26: return 33'sh00000000A;
			27: return 33'sh000000005;
			28: return 33'sh000000002;
			29: return 33'sh000000001;
			default: return '0;
		endcase
	endfunction

	// round half up from Q30 to Q1.15 and saturate to +/-32767
	function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] t;
		t = (v + 33'sd16384) >>> 15;
		if (t > 33'sd32767)
			return 16'sd32767;
		else if (t < -33'sd32767)
			return -16'sd32767;
		else
			return t[TRIG_W-1:0];
	endfunction

endpackage

[design/uvsph_seq.sv]
// ----------------------------------------------------------------------------
// uvsph_seq
// Cell sequencer: checks the cell against the counts and expands it into one
// vertex request per cycle while enabled, in triangle order.
// ----------------------------------------------------------------------------
module uvsph_seq
	import uvsph_pkg::*;
#(
	parameter int MAX_SLICES = MAX_SLICES_DEF,
	parameter int MAX_STACKS = MAX_STACKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [CNT_W-1:0] slice_count,
	input  logic [CNT_W-1:0] stack_count,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [IDX_W-1:0] stack_index,
	input  logic [IDX_W-1:0] slice_index,
	output req_t             req
);

	logic             cell_vld_q;
	logic [CNT_W-1:0] i_q, j_q, nt_q, ns_q;
	status_t          status_q;
	logic             first_a_q;
	logic [2:0]       total_q, v_q;

	logic [CNT_W-1:0] nt, ns, ii, jj;
	status_t          st;
	logic             first_a, last_emit, accept;
	logic [2:0]       total, u;
	logic             use_ln, use_on;
	req_t             req_s0;

	always_comb begin
		ns = (int'(slice_count) > MAX_SLICES) ? CNT_W'(MAX_SLICES) : slice_count;
		nt = (int'(stack_count) > MAX_STACKS) ? CNT_W'(MAX_STACKS) : stack_count;
		ii = {1'b0, stack_index};
		jj = {1'b0, slice_index};
		if (ns < 9'd3)
			st = ST_FEW_SLICES;
		else if (nt < 9'd2)
			st = ST_FEW_STACKS;
		else if (ii >= nt || jj >= ns)
			st = ST_RANGE;
		else
			st = ST_OK;
		first_a = (ii < nt - 9'd1);
		if (st != ST_OK)
			total = 3'd1;
		else if (first_a && ii != '0)
			total = 3'd6;
		else
			total = 3'd3;
	end

	assign last_emit = cell_vld_q && (v_q == total_q - 3'd1);
	assign in_stall  = cell_vld_q && !(en && last_emit);
	assign accept    = in_valid && !in_stall;

	// first triangle pair order is (c,c) (n,c) (n,n); second is (n,n) (c,n) (c,c)
	always_comb begin
		u = first_a_q ? v_q : v_q + 3'd3;
		case (u)
			3'd0: begin use_ln = 1'b0; use_on = 1'b0; end
			3'd1: begin use_ln = 1'b1; use_on = 1'b0; end
			3'd2: begin use_ln = 1'b1; use_on = 1'b1; end
			3'd3: begin use_ln = 1'b1; use_on = 1'b1; end
			3'd4: begin use_ln = 1'b0; use_on = 1'b1; end
			default: begin use_ln = 1'b0; use_on = 1'b0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_vld_q <= 1'b0;
			v_q        <= '0;
			req_s0     <= '0;
		end else begin
			if (en) begin
				req_s0.vld     <= cell_vld_q;
				req_s0.lat_idx <= use_ln ? i_q + 9'd1 : i_q;
				req_s0.lon_idx <= use_on ? j_q + 9'd1 : j_q;
				req_s0.nt      <= nt_q;
				req_s0.ns      <= ns_q;
				req_s0.status  <= status_q;
				req_s0.last    <= last_emit;
			end
			if (accept) begin
				cell_vld_q <= 1'b1;
				v_q        <= '0;
			end else if (en && cell_vld_q) begin
				v_q <= v_q + 3'd1;
				if (last_emit)
					cell_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			i_q       <= ii;
			j_q       <= jj;
			nt_q      <= nt;
			ns_q      <= ns;
			status_q  <= st;
			first_a_q <= first_a;
			total_q   <= total;
		end
	end

	assign req = req_s0;

endmodule

[design/uvsph_div.sv]
// ----------------------------------------------------------------------------
// uvsph_div
// Pipelined restoring divider for the angle fractions; a few quotient bits
// per stage.
// ----------------------------------------------------------------------------
module uvsph_div
	import uvsph_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [CNT_W-1:0]     den,
	output logic [ANG_W-1:0]     quot
);

	// numerator bits shift out at the top while quotient bits shift in below
	logic [DIV_NUM_W-1:0] w_s [DIV_STAGES+1];
	logic [CNT_W-1:0]     r_s [DIV_STAGES+1];
	logic [CNT_W-1:0]     d_s [DIV_STAGES+1];

	assign w_s[0] = num;
	assign r_s[0] = '0;
	assign d_s[0] = den;

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
		logic [DIV_NUM_W-1:0] w_d;
		logic [CNT_W-1:0]     r_d;

		always_comb begin
			logic [CNT_W:0] r2;
			w_d = w_s[s];
			r_d = r_s[s];
			r2  = '0;
			for (int t = 0; t < DIV_STEPS; t++) begin
				if (s * DIV_STEPS + t < DIV_NUM_W) begin
					r2  = {r_d, w_d[DIV_NUM_W-1]};
					w_d = {w_d[DIV_NUM_W-2:0], 1'b0};
					if (r2 >= {1'b0, d_s[s]}) begin
						r2     = r2 - {1'b0, d_s[s]};
						w_d[0] = 1'b1;
					end
					r_d = r2[CNT_W-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				w_s[s+1] <= w_d;
				r_s[s+1] <= r_d;
				d_s[s+1] <= d_s[s];
			end
		end
	end

	assign quot = w_s[DIV_STAGES][ANG_W-1:0];

endmodule

[design/uvsph_cordic.sv]
// ----------------------------------------------------------------------------
// uvsph_cordic
// Pipelined rotation-mode CORDIC giving Q1.15 sine and cosine of a turn
// fraction, with quadrant folding on the way out.
// ----------------------------------------------------------------------------
module uvsph_cordic
	import uvsph_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic [ANG_W-1:0]         angle,
	output logic signed [TRIG_W-1:0] sin_val,
	output logic signed [TRIG_W-1:0] cos_val
);

	logic signed [CW-1:0] x_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] y_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] z_s [CORDIC_STAGES+1];
	logic [1:0]           q_s [CORDIC_STAGES+1];

	logic signed [TRIG_W-1:0] s0, c0;
	logic signed [TRIG_W-1:0] sin_q, cos_q;

	assign x_s[0] = CORDIC_GAIN;
	assign y_s[0] = '0;
	assign z_s[0] = {3'b000, angle[ANG_W-3:0]};
	assign q_s[0] = angle[ANG_W-1:ANG_W-2];

	for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
		logic signed [CW-1:0] x_d, y_d, z_d;

		always_comb begin
			logic signed [CW-1:0] dx, dy;
			x_d = x_s[s];
			y_d = y_s[s];
			z_d = z_s[s];
			dx  = '0;
			dy  = '0;
			for (int t = 0; t < CORDIC_PER; t++) begin
				if (s * CORDIC_PER + t < CORDIC_N) begin
					dx = y_d >>> (s * CORDIC_PER + t);
					dy = x_d >>> (s * CORDIC_PER + t);
					if (!z_d[CW-1]) begin
						x_d = x_d - dx;
						y_d = y_d + dy;
						z_d = z_d - atan_turn(s * CORDIC_PER + t);
					end else begin
						x_d = x_d + dx;
						y_d = y_d - dy;
						z_d = z_d + atan_turn(s * CORDIC_PER + t);
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[s+1] <= x_d;
				y_s[s+1] <= y_d;
				z_s[s+1] <= z_d;
				q_s[s+1] <= q_s[s];
			end
		end
	end

	assign c0 = to_q15(x_s[CORDIC_STAGES]);
	assign s0 = to_q15(y_s[CORDIC_STAGES]);

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[CORDIC_STAGES])
				2'd0: begin sin_q <= s0;  cos_q <= c0;  end
				2'd1: begin sin_q <= c0;  cos_q <= -s0; end
				2'd2: begin sin_q <= -s0; cos_q <= -c0; end
				default: begin sin_q <= -c0; cos_q <= s0; end
			endcase
		end
	end

	assign sin_val = sin_q;
	assign cos_val = cos_q;

endmodule

[design/uv_sphere_cell_vertices_core.sv]
// ----------------------------------------------------------------------------
// uv_sphere_cell_vertices_core
// Expands UV sphere cells into triangle vertex positions in signed Q8.8.
// ----------------------------------------------------------------------------
// One cell is taken per transaction and expands into 1 (error), 3 (top or
// bottom stack) or 6 (middle stack) vertex transactions. The sequencer issues
// one vertex per cycle unless the output stalls, and it takes the next cell
// as it issues the last vertex of the current one, so a run of cells goes
// with no gap and the output carries one vertex per cycle while not stalled.
// Each vertex passes the sequencer's request register, two divider pipelines
// for its angles (DIV_STAGES = 7), two CORDIC lanes (CORDIC_STAGES + 1 = 11),
// two multiply stages and the output register. A stall on the output freezes
// the whole pipeline; nothing is dropped.
// Configuration must only be written while the core is empty.
module uv_sphere_cell_vertices_core
	import uvsph_pkg::*;
#(
	parameter int MAX_SLICES = MAX_SLICES_DEF,
	parameter int MAX_STACKS = MAX_STACKS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [IDX_W-1:0]        stack_index,
	input  logic [IDX_W-1:0]        slice_index,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] pos_z,
	output logic [1:0]              status,
	output logic                    last_vertex
);

	localparam int SIDE_D = DIV_STAGES + CORDIC_LAT;

	logic [RAD_W-1:0] radius_q;
	logic [CNT_W-1:0] slice_count_q, stack_count_q;

	logic en;
	req_t req;

	logic [DIV_NUM_W-1:0] lat_num, lon_num;
	logic [ANG_W-1:0]     lat_quot, lon_quot, lat_ang;

	logic signed [TRIG_W-1:0] sp, cp, st, ct;

	side_t side_s [SIDE_D];

	logic signed [CW-1:0]     rcp_s1;
	logic signed [POS_W-1:0]  py_s1;
	logic signed [TRIG_W-1:0] st_s1, ct_s1;
	side_t                    side_s1;

	logic signed [POS_W-1:0] px_s2, py_s2, pz_s2;
	side_t                   side_s2;

	logic signed [CW-1:0]   py_full;
	logic signed [48:0]     px_full, pz_full;
	logic signed [48:0]     px_rnd, pz_rnd;
	logic signed [CW-1:0]   py_rnd;

	logic                    out_vld_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	status_t                 status_q;
	logic                    last_q;

	// configuration registers; writes to an unknown index are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= RADIUS_RST;
			slice_count_q <= SLICES_RST;
			stack_count_q <= STACKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RADIUS: radius_q      <= cfg_data;
				CFG_SLICES: slice_count_q <= cfg_data[CNT_W-1:0];
				CFG_STACKS: stack_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign en = !(out_vld_q && out_stall);

	uvsph_seq #(
		.MAX_SLICES(MAX_SLICES),
		.MAX_STACKS(MAX_STACKS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.slice_count (slice_count_q),
		.stack_count (stack_count_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.stack_index (stack_index),
		.slice_index (slice_index),
		.req         (req)
	);

	// latitude uses index * 2^31 / stacks, longitude index * 2^32 / slices
	assign lat_num = {1'b0, req.lat_idx, 31'b0} + DIV_NUM_W'(req.nt >> 1);
	assign lon_num = {req.lon_idx, 32'b0} + DIV_NUM_W'(req.ns >> 1);

	uvsph_div u_div_lat (
		.clk  (clk),
		.en   (en),
		.num  (lat_num),
		.den  (req.nt),
		.quot (lat_quot)
	);

	uvsph_div u_div_lon (
		.clk  (clk),
		.en   (en),
		.num  (lon_num),
		.den  (req.ns),
		.quot (lon_quot)
	);

	assign lat_ang = 32'h4000_0000 - lat_quot;

	uvsph_cordic u_cordic_lat (
		.clk     (clk),
		.en      (en),
		.angle   (lat_ang),
		.sin_val (sp),
		.cos_val (cp)
	);

	uvsph_cordic u_cordic_lon (
		.clk     (clk),
		.en      (en),
		.angle   (lon_quot),
		.sin_val (st),
		.cos_val (ct)
	);

	// status and last flag travel alongside the divider and CORDIC stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SIDE_D; k++)
				side_s[k] <= '0;
		end else if (en) begin
			side_s[0] <= '{vld: req.vld, status: req.status, last: req.last};
			for (int k = 1; k < SIDE_D; k++)
				side_s[k] <= side_s[k-1];
		end
	end

	assign py_full = $signed({1'b0, radius_q}) * sp;
	assign py_rnd  = (py_full + 33'sd16384) >>> 15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_s1 <= '0;
		else if (en)
			side_s1 <= side_s[SIDE_D-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rcp_s1 <= $signed({1'b0, radius_q}) * cp;
			py_s1  <= py_rnd[POS_W-1:0];
			st_s1  <= st;
			ct_s1  <= ct;
		end
	end

	assign px_full = rcp_s1 * st_s1;
	assign pz_full = rcp_s1 * ct_s1;
	assign px_rnd  = (px_full + 49'sd536870912) >>> 30;
	assign pz_rnd  = (pz_full + 49'sd536870912) >>> 30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_s2 <= '0;
		else if (en)
			side_s2 <= side_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= px_rnd[POS_W-1:0];
			py_s2 <= py_s1;
			pz_s2 <= pz_rnd[POS_W-1:0];
		end
	end

	// output register; error transactions carry zero positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= side_s2.vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= side_s2.status;
			last_q   <= side_s2.last;
			if (side_s2.status != ST_OK) begin
				pos_x_q <= '0;
				pos_y_q <= '0;
				pos_z_q <= '0;
			end else begin
				pos_x_q <= px_s2;
				pos_y_q <= py_s2;
				pos_z_q <= pz_s2;
			end
		end
	end

	assign out_valid   = out_vld_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign pos_z       = pos_z_q;
	assign status      = status_q;
	assign last_vertex = last_q;

endmodule

[design/uvsph_chk.sv]
// ----------------------------------------------------------------------------
// uvsph_chk
// Port-level checks for the UV sphere cell vertex core, bound to the top.
// ----------------------------------------------------------------------------
module uvsph_chk
	import uvsph_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [POS_W-1:0] pos_x,
	input logic signed [POS_W-1:0] pos_y,
	input logic signed [POS_W-1:0] pos_z,
	input logic [1:0]              status,
	input logic                    last_vertex
);

	// an error transaction stands alone and carries no position
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |->
		(last_vertex && pos_x == '0 && pos_y == '0 && pos_z == '0))
		else $error("error transaction not final or carries a position");

	// a stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(pos_x) && $stable(pos_y) && $stable(pos_z) &&
		 $stable(status) && $stable(last_vertex)))
		else $error("stalled output transaction changed");

	// nothing leaves while reset is applied
	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind uv_sphere_cell_vertices_core uvsph_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pos_x       (pos_x),
	.pos_y       (pos_y),
	.pos_z       (pos_z),
	.status      (status),
	.last_vertex (last_vertex)
);
